// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants of the point to sphere projection unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pps_pkg;

  localparam int CoordW   = 18;
  localparam int RadiusW  = 17;
  localparam int MagW     = 18;
  localparam int ProdW    = 35;
  localparam int NumW     = 36;
  localparam int SumW     = 36;
  localparam int HalfW    = 18;
  localparam int SqNumW   = 72;
  localparam int AccW     = 80;
  localparam int NumBits  = 18;
  localparam int DataW    = 32;
  localparam int AddrW    = 3;

  localparam logic [RadiusW-1:0] RadiusReset = 17'd38011;
  localparam logic [MagW-1:0]    OutMaxPos   = 18'd131071;
  localparam logic [MagW-1:0]    OutMaxNeg   = 18'd131072;

  typedef enum logic [0:0] {
    REG_SPHERE_RADIUS = 1'b0
  } reg_idx_t;

  typedef logic signed [CoordW-1:0] coord_t;

endpackage

// ===== rtl/core/pps_in_if.sv =====
// ----------------------------------------------------------------------------
// pps_in_if
// Input point channel: valid/ready handshake with x, y, z payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pps_in_if;
  logic           valid;
  logic           ready;
  pps_pkg::coord_t in_x;
  pps_pkg::coord_t in_y;
  pps_pkg::coord_t in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

// ===== rtl/core/pps_out_if.sv =====
// ----------------------------------------------------------------------------
// pps_out_if
// Result channel: valid/ready handshake with projected point and flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pps_out_if;
  logic            valid;
  logic            ready;
  pps_pkg::coord_t out_x;
  pps_pkg::coord_t out_y;
  pps_pkg::coord_t out_z;
  logic            zero_length;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output zero_length, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input zero_length, output ready);
endinterface

// ===== rtl/core/project_point_to_sphere_unit.sv =====
// ----------------------------------------------------------------------------
// project_point_to_sphere_unit
// Scales a 3D point onto a sphere of configurable radius about the origin.
// ----------------------------------------------------------------------------
// Usage:
//   in_pt  : one point (x, y, z, signed Q2.16) per transaction.
//   out_pt : projected point, rounded to nearest and saturated, plus
//            zero_length, set (with zero coordinates) for a zero point.
//   cfg_*  : APB-style port; sphere_radius (unsigned Q1.16) at address 0.
// Throughput: one point per cycle while the output is not stalled.
// Pipeline: magnitude, square and product, sum and numerator, partial
//   product and seed (squared scaled numerator) registers, then one
//   pipeline stage per result bit (18) of an exact square-root-free
//   compare search, then the output register.
// Reset: all stage valid bits clear, sphere_radius returns to 38011.
// Stall: while a result waits and out_pt.ready is low, the whole
//   pipeline holds and in_pt.ready is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module project_point_to_sphere_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  pps_in_if.sink                    in_pt,
  pps_out_if.source                 out_pt,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [pps_pkg::AddrW-1:0] cfg_paddr,
  input  logic [pps_pkg::DataW-1:0] cfg_pwdata,
  output logic [pps_pkg::DataW-1:0] cfg_prdata,
  output logic                      cfg_pready
);

  localparam int CW  = pps_pkg::CoordW;
  localparam int RW  = pps_pkg::RadiusW;
  localparam int MW  = pps_pkg::MagW;
  localparam int PW  = pps_pkg::ProdW;
  localparam int NW  = pps_pkg::NumW;
  localparam int SW  = pps_pkg::SumW;
  localparam int HW  = pps_pkg::HalfW;
  localparam int QW  = pps_pkg::SqNumW;
  localparam int AW  = pps_pkg::AccW;
  localparam int NB  = pps_pkg::NumBits;

  // configuration
  logic [RW-1:0] radius_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == pps_pkg::REG_SPHERE_RADIUS) ?
                      {{(pps_pkg::DataW-RW){1'b0}}, radius_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= pps_pkg::RadiusReset;
    end else if (cfg_wr && cfg_paddr[2] == pps_pkg::REG_SPHERE_RADIUS) begin
      radius_r <= cfg_pwdata[RW-1:0];
    end
  end

  // pipeline enable
  logic en;
  logic out_v_r;

  assign en          = !out_v_r || out_pt.ready;
  assign in_pt.ready = en;

  // stage 1: magnitudes
  logic          v1_r;
  logic [MW-1:0] mag1_r [3];
  logic          neg1_r [3];
  logic [RW-1:0] r1_r;
  logic [CW-1:0] in_raw [3];

  assign in_raw[0] = in_pt.in_x;
  assign in_raw[1] = in_pt.in_y;
  assign in_raw[2] = in_pt.in_z;

  // stage 2: squares and products
  logic          v2_r;
  logic [SW-1:0] sq2_r  [3];
  logic [PW-1:0] p2_r   [3];
  logic          neg2_r [3];

  // stage 3: sum of squares and numerators
  logic          v3_r;
  logic [SW-1:0] s3_r;
  logic [NW-1:0] n3_r   [3];
  logic          neg3_r [3];

  // stage 4: partial products of the squared numerators
  logic            v4_r;
  logic [SW-1:0]   s4_r;
  logic [2*HW-1:0] hh4_r  [3];
  logic [2*HW-1:0] hl4_r  [3];
  logic [2*HW-1:0] ll4_r  [3];
  logic            neg4_r [3];

  // search stages: index 0 is the seed, index j has bit NB-j decided
  logic                 it_v_r [0:NB];
  logic [SW-1:0]        it_s_r [0:NB];
  logic                 it_z_r [0:NB];
  logic [QW-1:0]        it_q_r [0:NB][3];
  logic signed [AW-1:0] it_t_r [0:NB][3];
  logic signed [AW-1:0] it_u_r [0:NB][3];
  logic [MW-1:0]        it_m_r [0:NB][3];
  logic                 it_n_r [0:NB][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      it_v_r[0] <= 1'b0;
    end else if (en) begin
      v1_r      <= in_pt.valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      it_v_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r <= radius_r;
      s3_r <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      s4_r <= s3_r;
      it_s_r[0] <= s4_r;
      it_z_r[0] <= (s4_r == '0);
      for (int c = 0; c < 3; c++) begin
        neg1_r[c] <= in_raw[c][CW-1];
        mag1_r[c] <= in_raw[c][CW-1] ? MW'(~in_raw[c] + 1'b1) : MW'(in_raw[c]);
        sq2_r[c]  <= SW'(mag1_r[c] * mag1_r[c]);
        p2_r[c]   <= PW'(mag1_r[c] * r1_r);
        neg2_r[c] <= neg1_r[c];
        n3_r[c]   <= {p2_r[c], 1'b0};
        neg3_r[c] <= neg2_r[c];
        hh4_r[c]  <= n3_r[c][NW-1:HW] * n3_r[c][NW-1:HW];
        hl4_r[c]  <= n3_r[c][NW-1:HW] * n3_r[c][HW-1:0];
        ll4_r[c]  <= n3_r[c][HW-1:0] * n3_r[c][HW-1:0];
        neg4_r[c] <= neg3_r[c];
        it_q_r[0][c] <= {hh4_r[c], {(2*HW){1'b0}}}
                      + {{(QW-2*HW-HW-1){1'b0}}, hl4_r[c], {(HW+1){1'b0}}}
                      + {{(QW-2*HW){1'b0}}, ll4_r[c]};
        // seed: m = 0, d = -1, T = d*d*S, U = d*S
        it_t_r[0][c] <= signed'({{(AW-SW){1'b0}}, s4_r});
        it_u_r[0][c] <= -signed'({{(AW-SW){1'b0}}, s4_r});
        it_m_r[0][c] <= '0;
        it_n_r[0][c] <= neg4_r[c];
      end
    end
  end

  for (genvar j = 1; j <= NB; j++) begin : g_bit
    localparam int K = NB - j;
    logic signed [AW-1:0] s_ext;
    logic signed [AW-1:0] tc   [3];
    logic                 take [3];

    assign s_ext = signed'({{(AW-SW){1'b0}}, it_s_r[j-1]});

    // d grows by 2^(K+1): T' = T + 2^(K+2)*U + 2^(2K+2)*S
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        tc[c]   = it_t_r[j-1][c] + (it_u_r[j-1][c] <<< (K + 2)) + (s_ext <<< (2*K + 2));
        take[c] = tc[c] <= signed'({{(AW-QW){1'b0}}, it_q_r[j-1][c]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        it_v_r[j] <= 1'b0;
      end else if (en) begin
        it_v_r[j] <= it_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_s_r[j] <= it_s_r[j-1];
        it_z_r[j] <= it_z_r[j-1];
        for (int c = 0; c < 3; c++) begin
          it_q_r[j][c] <= it_q_r[j-1][c];
          it_n_r[j][c] <= it_n_r[j-1][c];
          if (take[c]) begin
            it_t_r[j][c] <= tc[c];
            it_u_r[j][c] <= it_u_r[j-1][c] + (s_ext <<< (K + 1));
            it_m_r[j][c] <= it_m_r[j-1][c] | (MW'(1) << K);
          end else begin
            it_t_r[j][c] <= it_t_r[j-1][c];
            it_u_r[j][c] <= it_u_r[j-1][c];
            it_m_r[j][c] <= it_m_r[j-1][c];
          end
        end
      end
    end
  end

  // output stage: sign, saturation, zero point
  logic [CW-1:0] res   [3];
  logic [CW-1:0] out_r [3];
  logic          zl_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      priority if (it_z_r[NB]) begin
        res[c] = '0;
      end else if (it_n_r[NB][c] && it_m_r[NB][c] != '0) begin
        res[c] = (it_m_r[NB][c] > pps_pkg::OutMaxNeg) ? CW'(~pps_pkg::OutMaxNeg + 1'b1)
                                                      : CW'(~it_m_r[NB][c] + 1'b1);
      end else begin
        res[c] = (it_m_r[NB][c] > pps_pkg::OutMaxPos) ? CW'(pps_pkg::OutMaxPos)
                                                      : CW'(it_m_r[NB][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= it_v_r[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zl_r <= it_z_r[NB];
      for (int c = 0; c < 3; c++) begin
        out_r[c] <= res[c];
      end
    end
  end

  assign out_pt.valid       = out_v_r;
  assign out_pt.out_x       = out_r[0];
  assign out_pt.out_y       = out_r[1];
  assign out_pt.out_z       = out_r[2];
  assign out_pt.zero_length = zl_r;

  `ASSERT_CLK(a_zero_out, clk, rst_n, out_pt.valid && out_pt.zero_length |-> out_pt.out_x == '0 && out_pt.out_y == '0 && out_pt.out_z == '0, "zero point gave nonzero result")
  `ASSERT_CLK(a_accept_enters, clk, rst_n, in_pt.valid && in_pt.ready |=> v1_r, "accepted point did not enter pipeline")
  `ASSERT_ALWAYS(a_stall_only, clk, !in_pt.ready |-> out_pt.valid && !out_pt.ready, "input stalled without output backpressure")

endmodule

// ===== test/project_point_to_sphere_unit_tb.sv =====
// ----------------------------------------------------------------------------
// project_point_to_sphere_unit_tb
// Drives points through the sphere projection unit under random idling on
// both channels, predicts each result exactly (rounded, saturated scaling
// by radius / length) and compares every result transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module project_point_to_sphere_unit_tb;

  localparam int NumRandom = 1400;
  localparam int Latency   = 24;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    pps_pkg::coord_t x;
    pps_pkg::coord_t y;
    pps_pkg::coord_t z;
    logic            zero_length;
  } point_res_t;

  typedef struct {
    pps_pkg::coord_t x;
    pps_pkg::coord_t y;
    pps_pkg::coord_t z;
    logic            known;
    point_res_t      res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [pps_pkg::AddrW-1:0] cfg_paddr = '0;
  logic [pps_pkg::DataW-1:0] cfg_pwdata = '0;
  logic [pps_pkg::DataW-1:0] cfg_prdata;
  logic cfg_pready;

  pps_in_if  in_pt ();
  pps_out_if out_pt ();

  project_point_to_sphere_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_pt(in_pt.sink), .out_pt(out_pt.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [pps_pkg::RadiusW-1:0] model_radius;
  point_res_t pending_points[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic sq_le(logic [63:0] a, logic [63:0] b,
                                 logic [63:0] c, logic [63:0] d);
    logic [127:0] l, r;
    l = a * b;
    r = c * d;
    return l <= r;
  endfunction

  function automatic logic [17:0] project_mag(logic [63:0] mag, logic [63:0] r,
                                              logic [63:0] s);
    logic [63:0] num, lo, hi, mid, dd;
    num = 2 * mag * r;
    lo = 0;
    hi = 64'h3FFFF;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      dd = 2 * mid - 1;
      if (sq_le(dd * dd, s, num, num)) lo = mid;
      else hi = mid - 1;
    end
    return lo[17:0];
  endfunction

  function automatic pps_pkg::coord_t project_coord(pps_pkg::coord_t c, logic [63:0] r,
                                                    logic [63:0] s);
    logic [63:0] mag;
    logic [17:0] m;
    mag = (c < 0) ? 64'(-int'(c)) : 64'(int'(c));
    m = project_mag(mag, r, s);
    if (c < 0 && m != 0) begin
      if (m > pps_pkg::OutMaxNeg) m = pps_pkg::OutMaxNeg;
      return pps_pkg::coord_t'(-int'(m));
    end
    if (m > pps_pkg::OutMaxPos) m = pps_pkg::OutMaxPos;
    return pps_pkg::coord_t'(m);
  endfunction

  function automatic point_res_t project_point(pps_pkg::coord_t x, pps_pkg::coord_t y,
                                               pps_pkg::coord_t z);
    point_res_t p;
    logic [63:0] s;
    s = 64'(longint'(x) * longint'(x)) + 64'(longint'(y) * longint'(y))
      + 64'(longint'(z) * longint'(z));
    if (s == 0) return '{x: '0, y: '0, z: '0, zero_length: 1'b1};
    p.x = project_coord(x, model_radius, s);
    p.y = project_coord(y, model_radius, s);
    p.z = project_coord(z, model_radius, s);
    p.zero_length = 1'b0;
    return p;
  endfunction

  task automatic write_radius(logic [pps_pkg::RadiusW-1:0] r);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= pps_pkg::AddrW'(pps_pkg::REG_SPHERE_RADIUS) << 2;
    cfg_pwdata <= pps_pkg::DataW'(r);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    model_radius = r;
  endtask

  task automatic wait_results();
    in_pt.valid <= 1'b0;
    @(negedge clk);
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  task automatic drain_points();
    wait_results();
    repeat (Latency + 4) @(negedge clk);
  endtask

  task automatic drive_point(pps_pkg::coord_t x, pps_pkg::coord_t y, pps_pkg::coord_t z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_pt.valid <= 1'b0;
      @(negedge clk);
    end
    in_pt.valid <= 1'b1;
    in_pt.in_x <= x;
    in_pt.in_y <= y;
    in_pt.in_z <= z;
    @(posedge clk);
    while (!in_pt.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_point(pps_pkg::coord_t x, pps_pkg::coord_t y, pps_pkg::coord_t z);
    pending_points = {pending_points, project_point(x, y, z)};
    drive_point(x, y, z);
  endtask

  function automatic pps_pkg::coord_t rand_coord(int mode);
    case (mode)
      0: return pps_pkg::coord_t'($urandom);
      1: return pps_pkg::coord_t'(int'($urandom_range(15)) - 8);
      2: return $urandom_range(1) ? 18'sh1FFFF : 18'sh20000;
      default: return pps_pkg::coord_t'(int'($urandom_range(4095)) - 2048);
    endcase
  endfunction

  always @(negedge clk) begin
    out_pt.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    point_res_t got, want;
    if (rst_n) begin
      if ((in_pt.valid && in_pt.ready) || (out_pt.valid && out_pt.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
      if (out_pt.valid && out_pt.ready) begin
        got = '{out_pt.out_x, out_pt.out_y, out_pt.out_z, out_pt.zero_length};
        if (pending_points.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction %p", got);
        end else begin
          want = pending_points.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  stim_row_t directed[12] = '{
    '{18'sd0, 18'sd0, 18'sd0, 1'b1, '{18'sd0, 18'sd0, 18'sd0, 1'b1}},
    '{18'sd65536, 18'sd0, 18'sd0, 1'b1, '{18'sd38011, 18'sd0, 18'sd0, 1'b0}},
    '{18'sd0, -18'sd65536, 18'sd0, 1'b1, '{18'sd0, -18'sd38011, 18'sd0, 1'b0}},
    '{18'sd0, 18'sd0, 18'sd131071, 1'b1, '{18'sd0, 18'sd0, 18'sd38011, 1'b0}},
    '{-18'sd131072, 18'sd0, 18'sd0, 1'b1, '{-18'sd38011, 18'sd0, 18'sd0, 1'b0}},
    '{18'sd1, 18'sd0, 18'sd0, 1'b1, '{18'sd38011, 18'sd0, 18'sd0, 1'b0}},
    '{18'sd131071, 18'sd131071, 18'sd131071, 1'b0, '{default: '0}},
    '{-18'sd131072, -18'sd131072, -18'sd131072, 1'b0, '{default: '0}},
    '{18'sd131071, -18'sd131072, 18'sd1, 1'b0, '{default: '0}},
    '{18'sd1, 18'sd1, -18'sd1, 1'b0, '{default: '0}},
    '{18'sd3, 18'sd4, 18'sd0, 1'b0, '{default: '0}},
    '{-18'sd1, 18'sd0, 18'sd131071, 1'b0, '{default: '0}}
  };

  logic [pps_pkg::RadiusW-1:0] radius_set[4] = '{17'd0, 17'd131071, 17'd1, 17'd65536};

  initial begin
    in_pt.valid = 1'b0;
    in_pt.in_x = '0;
    in_pt.in_y = '0;
    in_pt.in_z = '0;
    out_pt.ready = 1'b0;
    model_radius = pps_pkg::RadiusReset;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) begin
      if (directed[i].known) pending_points = {pending_points, directed[i].res};
      else pending_points = {pending_points,
                             project_point(directed[i].x, directed[i].y, directed[i].z)};
      drive_point(directed[i].x, directed[i].y, directed[i].z);
    end
    drain_points();
    foreach (radius_set[k]) begin
      write_radius(radius_set[k]);
      for (int j = 0; j < 4; j++) send_point(directed[6+j].x, directed[6+j].y, directed[6+j].z);
      send_point('0, '0, '0);
      drain_points();
    end
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 11 : 0;
      write_radius(phase == 2 ? pps_pkg::RadiusW'($urandom)
                              : pps_pkg::RadiusW'($urandom_range(131071, 30000)));
      for (int n = 0; n < NumRandom / 3; n++) begin
        int mode;
        mode = $urandom_range(9);
        mode = (mode < 5) ? 0 : (mode < 7) ? 3 : (mode < 9) ? 1 : 2;
        if ($urandom_range(49) == 0) send_point('0, '0, '0);
        else send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode));
        if (n == 200) wait_results();
      end
      drain_points();
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pps_pkg.sv
rtl/core/pps_in_if.sv
rtl/core/pps_out_if.sv
rtl/core/project_point_to_sphere_unit.sv
test/project_point_to_sphere_unit_tb.sv
